### src/swa_pkg.sv
// shared constants and types for the sliding window average block
package swa_pkg;

   localparam int WINDOW_DEPTH = 32;
   localparam int SAMPLE_W = 16;
   localparam int LEN_W = 6;
   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int EFF_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W = (EFF_W > LEN_W) ? EFF_W : LEN_W;
   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(SUM_W + 1);
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   typedef struct packed {
      logic valid;
      sum_type psum;
   } wave_type;

endpackage

### src/swa_if.sv
// valid/ready channel interfaces for samples and means
interface swa_req_if;
   logic valid;
   logic ready;
   swa_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface swa_rsp_if;
   logic valid;
   logic ready;
   swa_pkg::sample_type mean;

   modport source (output valid, output mean, input ready);
   modport sink (input valid, input mean, output ready);
endinterface

### src/swa_cell.sv
// one window cell: holds a sample and adds it to the passing partial sum when its index >= threshold
module swa_cell (
   input  logic clock,
   input  logic reset,
   input  logic shift_en,
   input  swa_pkg::sample_type sample_prev,
   output swa_pkg::sample_type sample_out,
   input  logic [swa_pkg::IDX_W-1:0] index,
   input  logic [swa_pkg::IDX_W-1:0] threshold,
   input  swa_pkg::wave_type wave_prev,
   output swa_pkg::wave_type wave_out
);

   swa_pkg::sample_type sample_ff, sample_in;
   logic valid_ff, valid_in;
   swa_pkg::sum_type psum_ff, psum_in;
   swa_pkg::sum_type addend;

   always_comb begin
      sample_in = shift_en ? sample_prev : sample_ff;
      addend = (index >= threshold) ? swa_pkg::SUM_W'(sample_ff) : '0;
      valid_in = wave_prev.valid;
      psum_in = wave_prev.valid ? (wave_prev.psum + addend) : psum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         sample_ff <= sample_in;
         valid_ff <= valid_in;
      end
      psum_ff <= psum_in;
   end

   assign sample_out = sample_ff;
   assign wave_out.valid = valid_ff;
   assign wave_out.psum = psum_ff;

endmodule

### src/swa_divider.sv
// serial restoring divider, one quotient bit per cycle, truncates toward zero
module swa_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  swa_pkg::sum_type dividend,
   input  logic [swa_pkg::EFF_W-1:0] divisor,
   output logic done,
   output swa_pkg::sample_type quotient
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [swa_pkg::CNT_W-1:0] count_ff, count_in;
   logic neg_ff, neg_in;
   logic [swa_pkg::SUM_W-1:0] quo_ff, quo_in;
   logic [swa_pkg::EFF_W-1:0] rem_ff, rem_in;
   logic [swa_pkg::EFF_W-1:0] div_ff, div_in;
   logic [swa_pkg::EFF_W:0] rem_shift;
   logic [swa_pkg::EFF_W:0] rem_trial;
   logic [swa_pkg::SUM_W-1:0] quo_signed;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      rem_shift = {rem_ff, quo_ff[swa_pkg::SUM_W-1]};
      rem_trial = rem_shift - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         count_in = swa_pkg::CNT_W'(swa_pkg::SUM_W);
         neg_in = dividend[swa_pkg::SUM_W-1];
         quo_in = dividend[swa_pkg::SUM_W-1] ? (-dividend) : dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, div_ff}) begin
            rem_in = rem_trial[swa_pkg::EFF_W-1:0];
            quo_in = {quo_ff[swa_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[swa_pkg::EFF_W-1:0];
            quo_in = {quo_ff[swa_pkg::SUM_W-2:0], 1'b0};
         end
         count_in = count_ff - swa_pkg::CNT_W'(1);
         if (count_ff == swa_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quo_signed = neg_ff ? (-quo_ff) : quo_ff;
   assign quotient = quo_signed[swa_pkg::SAMPLE_W-1:0];
   assign done = done_ff;

endmodule

### src/sliding_window_average.sv
// top level of the sliding window average: cell chain, divider and control
//
//   channel   dir   transfer when        payload
//   req_if    in    valid && ready       sample  (signed 16)
//   rsp_if    out   valid && ready       mean    (signed 16)
//   csr       in    csr_wr_en            csr_wr_data (window length, 6 bits)
//
// a mean passes from its sample transfer through the start register, the cell chain and
// the divider into the output register, and only then is the next sample taken: the partial
// sum walks the cell chain one cell a cycle, then the divider gives a bit a cycle
// reset clears the window to zero and sets the window length to 32
// a new sample is taken while the previous mean still waits in the output register
// a stalled result holds in the divider until the output register is free
module sliding_window_average (
   input  logic clock,
   input  logic reset,
   swa_req_if.sink req_if,
   swa_rsp_if.source rsp_if,
   input  logic csr_wr_en,
   input  logic [swa_pkg::LEN_W-1:0] csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic start_ff, start_in;
   logic rsp_valid_ff, rsp_valid_in;
   swa_pkg::sample_type mean_ff, mean_in;
   logic [swa_pkg::LEN_W-1:0] len_ff, len_in;

   logic accept;
   logic div_start;
   logic div_done;
   logic slot_free;
   swa_pkg::sample_type div_quotient;
   logic [swa_pkg::CMP_W-1:0] len_wide;
   logic [swa_pkg::CMP_W-1:0] eff_wide;
   logic [swa_pkg::CMP_W-1:0] thr_wide;
   logic [swa_pkg::EFF_W-1:0] eff_len;
   logic [swa_pkg::IDX_W-1:0] threshold;

   swa_pkg::sample_type sample_q [swa_pkg::WINDOW_DEPTH];
   swa_pkg::wave_type wave [swa_pkg::WINDOW_DEPTH+1];

   // effective length, clamped to one .. depth
   always_comb begin
      len_wide = swa_pkg::CMP_W'(len_ff);
      if (len_wide == '0) begin
         eff_wide = swa_pkg::CMP_W'(1);
      end else if (len_wide > swa_pkg::CMP_W'(swa_pkg::WINDOW_DEPTH)) begin
         eff_wide = swa_pkg::CMP_W'(swa_pkg::WINDOW_DEPTH);
      end else begin
         eff_wide = len_wide;
      end
      thr_wide = swa_pkg::CMP_W'(swa_pkg::WINDOW_DEPTH) - eff_wide;
      eff_len = eff_wide[swa_pkg::EFF_W-1:0];
      threshold = thr_wide[swa_pkg::IDX_W-1:0];
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept = req_if.valid && req_if.ready;
   assign wave[0].valid = start_ff;
   assign wave[0].psum = '0;

   for (genvar i = 0; i < swa_pkg::WINDOW_DEPTH; i++) begin : g_cell
      swa_pkg::sample_type sample_prev;
      if (i == swa_pkg::WINDOW_DEPTH - 1) begin : g_head
         assign sample_prev = req_if.sample;
      end else begin : g_body
         assign sample_prev = sample_q[i+1];
      end
      swa_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (accept),
         .sample_prev (sample_prev),
         .sample_out  (sample_q[i]),
         .index       (swa_pkg::IDX_W'(i)),
         .threshold   (threshold),
         .wave_prev   (wave[i]),
         .wave_out    (wave[i+1])
      );
   end

   assign div_start = (state_ff == ST_SUM) && wave[swa_pkg::WINDOW_DEPTH].valid;

   swa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wave[swa_pkg::WINDOW_DEPTH].psum),
      .divisor  (eff_len),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in = state_ff;
      start_in = accept;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      mean_in = mean_ff;
      len_in = csr_wr_en ? csr_wr_data : len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (div_start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  mean_in = div_quotient;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               mean_in = div_quotient;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_ff <= swa_pkg::LEN_RESET;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff <= len_in;
      end
      mean_ff <= mean_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.mean = mean_ff;

endmodule

### bench/sliding_window_average_checker.sv
// checker for the sliding window average: predicts each mean and compares transfers
`timescale 1ns / 1ps

module sliding_window_average_checker (
   input  logic clock,
   input  logic reset,
   swa_req_if req_mon,
   swa_rsp_if rsp_mon,
   input  logic csr_wr_en,
   input  logic [swa_pkg::LEN_W-1:0] csr_wr_data,
   output int mismatches,
   output int pending
);

   swa_pkg::sample_type window_copy [swa_pkg::WINDOW_DEPTH];
   logic [swa_pkg::LEN_W-1:0] length_copy;
   swa_pkg::sample_type expected_means [$];

   function automatic swa_pkg::sample_type shift_and_average(input swa_pkg::sample_type s);
      int n;
      int total;
      total = 0;
      for (int i = 0; i < swa_pkg::WINDOW_DEPTH - 1; i++) begin
         window_copy[i] = window_copy[i + 1];
      end
      window_copy[swa_pkg::WINDOW_DEPTH - 1] = s;
      n = int'(length_copy);
      if (n == 0) begin
         n = 1;
      end
      if (n > swa_pkg::WINDOW_DEPTH) begin
         n = swa_pkg::WINDOW_DEPTH;
      end
      for (int i = swa_pkg::WINDOW_DEPTH - n; i < swa_pkg::WINDOW_DEPTH; i++) begin
         total += int'(window_copy[i]);
      end
      return swa_pkg::sample_type'(total / n);
   endfunction

   initial begin
      mismatches = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      swa_pkg::sample_type oldest;
      if (reset) begin
         for (int i = 0; i < swa_pkg::WINDOW_DEPTH; i++) begin
            window_copy[i] = '0;
         end
         length_copy = swa_pkg::LEN_RESET;
         expected_means.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_means.size() == 0) begin
               $error("mean transfer with nothing expected: actual %0d", rsp_mon.mean);
               mismatches++;
            end else begin
               oldest = expected_means.pop_front();
               if (rsp_mon.mean !== oldest) begin
                  $error("mean mismatch: expected %0d, actual %0d", oldest, rsp_mon.mean);
                  mismatches++;
               end
            end
         end
         if (csr_wr_en) begin
            length_copy = csr_wr_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_means.push_back(shift_and_average(req_mon.sample));
         end
      end
      pending = expected_means.size();
   end

endmodule

### bench/sliding_window_average_test.sv
// testbench top for the sliding window average: stimulus, stalls and verdict
`timescale 1ns / 1ps

module sliding_window_average_test;

   localparam int SETTLE_CYCLES = 80;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASE_ITEMS = 93;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [swa_pkg::LEN_W-1:0] csr_wr_data = '0;
   int mismatches;
   int pending;
   int idle_cycles = 0;
   int burst_left = 0;
   swa_pkg::sample_type burst_value = '0;

   swa_req_if req_chan ();
   swa_rsp_if rsp_chan ();

   sliding_window_average uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_chan),
      .rsp_if(rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   sliding_window_average_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_mon(req_chan),
      .rsp_mon(rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatches(mismatches),
      .pending(pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.sample = '0;
      rsp_chan.ready = 1'b0;
   end

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 60);
   endfunction

   function automatic swa_pkg::sample_type random_sample();
      int r;
      r = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         return burst_value;
      end
      if (r < 8) begin
         case ($urandom_range(0, 2))
            0: burst_value = 16'sh7fff;
            1: burst_value = -16'sh8000;
            default: burst_value = swa_pkg::sample_type'($urandom());
         endcase
         burst_left = $urandom_range(10, 40);
         return burst_value;
      end
      if (r < 20) begin
         return ($urandom_range(0, 1) == 1) ? 16'sh7fff : -16'sh8000;
      end
      if (r < 40) begin
         return swa_pkg::sample_type'($signed($urandom_range(0, 128)) - 64);
      end
      return swa_pkg::sample_type'($urandom());
   endfunction

   task automatic push_sample(input swa_pkg::sample_type s, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= s;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_for_means();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_window_length(input logic [swa_pkg::LEN_W-1:0] len);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // result side back-pressure
   initial begin
      int hold;
      int stall;
      @(negedge reset);
      @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         rsp_chan.ready <= 1'b1;
         repeat (hold) @(posedge clock);
         stall = random_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      swa_pkg::sample_type directed [$];
      logic [swa_pkg::LEN_W-1:0] lengths [10];
      bit dense;
      directed = '{16'sd0, -16'sd1, -16'sd31, -16'sd33, 16'sd1, 16'sh7fff, 16'sh7fff,
                   16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
                   -16'sh8000, 16'sh5555, -16'sh5556, 16'sd1, -16'sd1, 16'sh7fff,
                   -16'sh8000, 16'sd0};
      lengths = '{6'd1, 6'd0, 6'd63, 6'd33, 6'd32, 6'd2, 6'd31, 6'd16, 6'd5, 6'd0};
      lengths[9] = swa_pkg::LEN_W'($urandom_range(0, 63));
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset length of 32 with a cleared window
      foreach (directed[i]) begin
         push_sample(directed[i], random_gap());
      end

      foreach (lengths[p]) begin
         wait_for_means();
         set_window_length(lengths[p]);
         dense = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == 45) begin
               wait_for_means();
            end
            push_sample(random_sample(), dense ? 0 : random_gap());
         end
      end

      wait_for_means();
      @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### files.f
src/swa_pkg.sv
src/swa_if.sv
src/swa_cell.sv
src/swa_divider.sv
src/sliding_window_average.sv
bench/sliding_window_average_checker.sv
bench/sliding_window_average_test.sv
